@@ sv/fpft_pkg.sv @@
// Shared types and constants of the first pinned flow tracker.
`default_nettype none

package fpft_pkg;

	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_INIT  = 2'd1;
	localparam logic [1:0] OP_PIN   = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_QUERY   = 1'b1;

	localparam logic CFG_PIN_LOW  = 1'b0;
	localparam logic CFG_PIN_HIGH = 1'b1;

	localparam int WELL_W  = 16;
	localparam int FLOW_W  = 10;
	localparam int SMP_W   = 16;
	localparam int TALLY_W = 17;
	localparam int PF_W    = 11;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	typedef struct packed {
		logic [1:0]        op;
		logic              in_range;
		logic              mask;
		logic [FLOW_W-1:0] flow;
	} tbl_req_t;

	typedef struct packed {
		logic                   vld;
		logic signed [PF_W-1:0] pinned_flow;
	} tbl_rsp_t;

	typedef struct packed {
		logic                   kind;
		logic signed [PF_W-1:0] pinned_flow;
		logic                   well_pinned;
		logic [TALLY_W-1:0]     total_count;
		logic [TALLY_W-1:0]     high_count;
		logic [TALLY_W-1:0]     low_count;
		logic [FLOW_W-1:0]      flow_done;
	} res_t;

endpackage

`default_nettype wire

@@ sv/fpft_table.sv @@
// First pinned flow table: synchronous memory with read-modify-write and forwarding.
`default_nettype none

module fpft_table import fpft_pkg::*; #(
	parameter int WELL_COUNT = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_vld,
	input  wire tbl_req_t          req,
	input  wire logic [WELL_W-1:0] well,
	output tbl_rsp_t               rsp
);

	localparam int AW = (WELL_COUNT > 1) ? $clog2(WELL_COUNT) : 1;

	logic [PF_W-1:0] mem [WELL_COUNT];

	logic [AW-1:0]   addr;
	logic [AW-1:0]   addr_s1;
	tbl_req_t        req_s1;
	logic            vld_s1;
	logic [PF_W-1:0] rd_q;
	logic            fwd_q;
	logic [PF_W-1:0] fwd_data_q;
	logic [PF_W-1:0] cur;
	logic            wr_en;
	logic [PF_W-1:0] wr_data;

	assign addr = AW'(well);
	assign cur  = fwd_q ? fwd_data_q : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (req_vld) begin
			rd_q <= mem[addr];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = cur;
		case (req_s1.op)
			OP_INIT: begin
				wr_en   = vld_s1 && req_s1.in_range;
				wr_data = req_s1.mask ? '0 : '1;
			end
			OP_PIN: begin
				wr_en   = vld_s1 && req_s1.in_range &&
					(($signed(cur) < 0) || ($signed(cur) > $signed({1'b0, req_s1.flow})));
				wr_data = {1'b0, req_s1.flow};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			vld_s1 <= req_vld;
			fwd_q  <= wr_en && req_vld && (addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
		if (req_vld) begin
			req_s1  <= req;
			addr_s1 <= addr;
		end
	end

	assign rsp.vld         = vld_s1 && (req_s1.op == OP_QUERY);
	assign rsp.pinned_flow = req_s1.in_range ? $signed(cur) : '1;

endmodule

`default_nettype wire

@@ sv/fpft_outq.sv @@
// Result queue between the table pipeline and the output stream.
`default_nettype none

module fpft_outq import fpft_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire res_t          push_data,
	output logic [OQ_CNT_W-1:0] count,
	output logic               valid,
	input  wire logic          ready,
	output res_t               data
);

	res_t                ent_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && ready;
	assign data  = ent_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/first_pinned_flow_tracker.sv @@
// Top level of the first pinned flow tracker: tallies, table pipeline and result queue.
//
// channel  direction  fields
// s_axis   in         tuser cmd, tlast last_frame, tdata well/flow/sample/mask/last_well
// m_axis   out        tuser kind, tdata flow_done/counts/well_pinned/pinned_flow
// cfg      in         cfg_we, cfg_idx, cfg_data (pin_low, pin_high)
//
// One item per cycle unless input is held off. The table is read on the transfer, modified
// and written back the next cycle; a result is registered, then queued. The table holds no
// valid bits and has no clearing pass: entries are undefined until an init or a pinned
// sample writes them. Reset clears tallies and queue and sets thresholds to 0 and 16383.
// A four-entry result queue absorbs output stalls; input is held off when it would overflow.
`default_nettype none

module first_pinned_flow_tracker import fpft_pkg::*; #(
	parameter int WELL_COUNT = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // well, flow, sample, mask_pinned, last_well, zero pad
	input  wire logic [1:0]  s_axis_tuser,  // cmd
	input  wire logic        s_axis_tlast,  // last_frame
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // flow_done, low, high, total, well_pinned,
	                                        // pinned_flow, zero pad
	output logic             m_axis_tuser,  // kind
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data
);

	logic                     acc;
	logic [1:0]               cmd;
	logic [WELL_W-1:0]        well;
	logic [FLOW_W-1:0]        flow;
	logic signed [SMP_W-1:0]  sample;
	logic                     mask_pinned;
	logic                     last_frame;
	logic                     last_well;
	logic                     in_range;

	logic signed [SMP_W-1:0]  pin_low_q;
	logic signed [SMP_W-1:0]  pin_high_q;
	logic                     found_q;
	logic [TALLY_W-1:0]       low_q;
	logic [TALLY_W-1:0]       high_q;

	logic                     is_low;
	logic                     is_high;
	logic                     found_nx;
	logic [TALLY_W-1:0]       low_up;
	logic [TALLY_W-1:0]       high_up;
	logic [TALLY_W-1:0]       low_nx;
	logic [TALLY_W-1:0]       high_nx;
	logic [TALLY_W:0]         tot_sum;
	logic                     sum_vld;
	res_t                     sum;
	tbl_req_t                 req;

	logic                     sum_vld_s1;
	res_t                     sum_s1;
	tbl_rsp_t                 rsp;
	res_t                     qry;
	logic                     push;
	res_t                     push_data;
	logic [OQ_CNT_W-1:0]      oq_cnt;
	res_t                     head;

	assign cmd         = s_axis_tuser;
	assign well        = s_axis_tdata[15:0];
	assign flow        = s_axis_tdata[25:16];
	assign sample      = $signed(s_axis_tdata[41:26]);
	assign mask_pinned = s_axis_tdata[42];
	assign last_well   = s_axis_tdata[43];
	assign last_frame  = s_axis_tlast;
	assign in_range    = 32'(well) < WELL_COUNT;
	assign acc         = s_axis_tvalid && s_axis_tready;

	assign is_low  = sample <= pin_low_q;
	assign is_high = sample >= pin_high_q;

	always_comb begin
		found_nx     = found_q;
		low_up       = low_q;
		high_up      = high_q;
		low_nx       = low_q;
		high_nx      = high_q;
		sum_vld      = 1'b0;
		req.op       = OP_NONE;
		req.in_range = in_range;
		req.mask     = mask_pinned;
		req.flow     = flow;
		case (cmd)
			CMD_INIT: begin
				req.op = OP_INIT;
			end
			CMD_QUERY: begin
				req.op = OP_QUERY;
			end
			CMD_SAMPLE: begin
				if (!found_q && (is_low || is_high)) begin
					req.op   = OP_PIN;
					found_nx = 1'b1;
					if (is_low) begin
						low_up = (low_q == TALLY_MAX) ? low_q : low_q + 1'b1;
					end else begin
						high_up = (high_q == TALLY_MAX) ? high_q : high_q + 1'b1;
					end
				end
				low_nx  = low_up;
				high_nx = high_up;
				if (last_frame) begin
					found_nx = 1'b0;
					if (last_well) begin
						sum_vld = 1'b1;
						low_nx  = '0;
						high_nx = '0;
					end
				end
			end
			default: begin
				req.op = OP_NONE;
			end
		endcase
	end

	assign tot_sum = {1'b0, low_up} + {1'b0, high_up};

	always_comb begin
		sum             = '0;
		sum.kind        = KIND_SUMMARY;
		sum.flow_done   = flow;
		sum.low_count   = low_up;
		sum.high_count  = high_up;
		sum.total_count = tot_sum[TALLY_W] ? TALLY_MAX : tot_sum[TALLY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_low_q  <= '0;
			pin_high_q <= 16'sd16383;
			found_q    <= 1'b0;
			low_q      <= '0;
			high_q     <= '0;
			sum_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PIN_LOW:  pin_low_q  <= $signed(cfg_data);
					CFG_PIN_HIGH: pin_high_q <= $signed(cfg_data);
					default:      pin_low_q  <= pin_low_q;
				endcase
			end
			if (acc) begin
				found_q <= found_nx;
				low_q   <= low_nx;
				high_q  <= high_nx;
			end
			sum_vld_s1 <= acc && sum_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sum_s1 <= sum;
		end
	end

	fpft_table #(
		.WELL_COUNT(WELL_COUNT)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_vld (acc),
		.req     (req),
		.well    (well),
		.rsp     (rsp)
	);

	always_comb begin
		qry             = '0;
		qry.kind        = KIND_QUERY;
		qry.pinned_flow = rsp.pinned_flow;
		qry.well_pinned = ~rsp.pinned_flow[PF_W-1];
	end

	assign push      = sum_vld_s1 || rsp.vld;
	assign push_data = sum_vld_s1 ? sum_s1 : qry;

	fpft_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (oq_cnt),
		.valid     (m_axis_tvalid),
		.ready     (m_axis_tready),
		.data      (head)
	);

	assign s_axis_tready = (oq_cnt + {{(OQ_CNT_W-1){1'b0}}, push}) < OQ_CNT_W'(OQ_DEPTH);

	assign m_axis_tdata = {7'd0, head.pinned_flow, head.well_pinned, head.total_count,
		head.high_count, head.low_count, head.flow_done};
	assign m_axis_tuser = head.kind;

endmodule

`default_nettype wire

@@ sv/fpft_checker.sv @@
// Port checker for the first pinned flow tracker, bound to the top level.
`default_nettype none

module fpft_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	logic [17:0] lh_sum;

	assign lh_sum = {1'b0, m_axis_tdata[26:10]} + {1'b0, m_axis_tdata[43:27]};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			(m_axis_tdata[60:44] == (lh_sum[17] ? 17'h1FFFF : lh_sum[16:0])) &&
			(m_axis_tdata[72:61] == 12'd0))
		else $error("summary total does not match low plus high");

	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[60:0] == 61'd0) && (m_axis_tdata[61] == !m_axis_tdata[72]))
		else $error("malformed query answer");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without an input transfer two cycles earlier");

endmodule

bind first_pinned_flow_tracker fpft_checker u_fpft_checker (.*);

`default_nettype wire
